FILE: rtl/hca_pkg.sv
// Shared constants for the haversine central angle pipeline.
package hca_pkg;
  localparam int unsigned QW = 31;
  localparam logic [QW-1:0] Q_ONE = 31'h4000_0000;
  localparam logic [23:0] RAD_HALF_DEG = 24'd9370165;
  localparam logic [24:0] RAD_DEG = 25'd18740330;
  localparam logic [QW-1:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [31:0] PI_Q30 = 32'd3373259426;
  localparam int unsigned NTERMS = 6;
  localparam int unsigned SIN_DIV [NTERMS] = '{156, 110, 72, 42, 20, 6};
  localparam int unsigned COS_DIV [NTERMS] = '{132, 90, 56, 30, 12, 2};
endpackage

FILE: rtl/haversine_central_angle.sv
// Top level of the haversine central angle pipeline.
//
//   channel | direction | handshake                | payload
//   input   | in        | in_valid_i / in_stall_o  | start/end latitude and longitude
//   output  | out       | out_valid_o / out_stall_i | central_angle_o
//
// One beat is taken every cycle unless an output stall freezes the pipeline.
// Most of the pipeline is the arcsine search: 31 steps, each a 15-stage sine-squared
// unit and a result register.
// Reset clears only the valid bits of every stage.
// A stall with out_valid_o high freezes the whole pipeline, and in_stall_o follows it.
module haversine_central_angle
  import hca_pkg::*;
#(
  parameter int unsigned OUT_FRAC_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [7:0]         start_latitude_i,
  input  logic signed [8:0]         start_longitude_i,
  input  logic signed [7:0]         end_latitude_i,
  input  logic signed [8:0]         end_longitude_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [OUT_FRAC_BITS+1:0]  central_angle_o
);
  localparam int unsigned Sh    = 30 - OUT_FRAC_BITS;
  localparam int unsigned OW    = OUT_FRAC_BITS + 2;
  localparam int unsigned NSrch = 31;
  localparam logic [OW-1:0] AngLim = OW'(PI_Q30 >> Sh);

  logic en;
  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  logic signed [7:0] lat1c, lat2c;
  logic signed [8:0] latd;
  logic signed [9:0] lond;
  logic [8:0]        lonabs;
  logic [8:0]        lonmod;
  logic [7:0]        dlat_d, dlon_d;
  logic [6:0]        alat1_d, alat2_d;

  always_comb begin
    if (start_latitude_i > 8'sd90) begin
      lat1c = 8'sd90;
    end else if (start_latitude_i < -8'sd90) begin
      lat1c = -8'sd90;
    end else begin
      lat1c = start_latitude_i;
    end
    if (end_latitude_i > 8'sd90) begin
      lat2c = 8'sd90;
    end else if (end_latitude_i < -8'sd90) begin
      lat2c = -8'sd90;
    end else begin
      lat2c = end_latitude_i;
    end
    latd    = 9'(lat1c) - 9'(lat2c);
    dlat_d  = latd[8] ? 8'(-latd) : 8'(latd);
    alat1_d = lat1c[7] ? 7'(-lat1c) : 7'(lat1c);
    alat2_d = lat2c[7] ? 7'(-lat2c) : 7'(lat2c);
    lond    = 10'(start_longitude_i) - 10'(end_longitude_i);
    lonabs  = lond[9] ? 9'(-lond) : 9'(lond);
    lonmod  = (lonabs >= 9'd360) ? 9'(lonabs - 9'd360) : lonabs;
    dlon_d  = (lonmod > 9'd180) ? 8'(9'd360 - lonmod) : 8'(lonmod);
  end

  logic       p0_v_q;
  logic [7:0] dlat_q, dlon_q;
  logic [6:0] alat1_q, alat2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_v_q <= 1'b0;
    end else if (en) begin
      p0_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dlat_q  <= dlat_d;
      dlon_q  <= dlon_d;
      alat1_q <= alat1_d;
      alat2_q <= alat2_d;
    end
  end

  logic          p1_v_q;
  logic [QW-1:0] xdlat_q, xdlon_q, xlat1_q, xlat2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
    end else if (en) begin
      p1_v_q <= p0_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      xdlat_q <= QW'(32'(dlat_q) * 32'(RAD_HALF_DEG));
      xdlon_q <= QW'(32'(dlon_q) * 32'(RAD_HALF_DEG));
      xlat1_q <= QW'(32'(alat1_q) * 32'(RAD_DEG));
      xlat2_q <= QW'(32'(alat2_q) * 32'(RAD_DEG));
    end
  end

  logic        tr_v;
  logic [31:0] sdlat, sdlon, cos1, cos2;

  hca_trig #(.IsCos(1'b0), .TagW(1)) u_sdlat (
    .clk_i, .rst_ni, .en_i(en), .valid_i(p1_v_q), .x_i(xdlat_q), .tag_i(1'b0),
    .valid_o(tr_v), .y_o(sdlat), .tag_o()
  );
  hca_trig #(.IsCos(1'b0), .TagW(1)) u_sdlon (
    .clk_i, .rst_ni, .en_i(en), .valid_i(p1_v_q), .x_i(xdlon_q), .tag_i(1'b0),
    .valid_o(), .y_o(sdlon), .tag_o()
  );
  hca_trig #(.IsCos(1'b1), .TagW(1)) u_cos1 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(p1_v_q), .x_i(xlat1_q), .tag_i(1'b0),
    .valid_o(), .y_o(cos1), .tag_o()
  );
  hca_trig #(.IsCos(1'b1), .TagW(1)) u_cos2 (
    .clk_i, .rst_ni, .en_i(en), .valid_i(p1_v_q), .x_i(xlat2_q), .tag_i(1'b0),
    .valid_o(), .y_o(cos2), .tag_o()
  );

  logic        p2_v_q, p3_v_q;
  logic [31:0] cc_q, sdlat2_q, sdlon2_q, m_q, sdlat3_q;
  logic [63:0] cc_prod, m_prod;
  logic [32:0] hsum;

  assign cc_prod = 64'(cos1) * 64'(cos2);
  assign m_prod  = 64'(cc_q) * 64'(sdlon2_q);
  assign hsum    = 33'(sdlat3_q) + 33'(m_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
    end else if (en) begin
      p2_v_q <= tr_v;
      p3_v_q <= p2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cc_q     <= cc_prod[61:30];
      sdlat2_q <= sdlat;
      sdlon2_q <= sdlon;
      m_q      <= m_prod[61:30];
      sdlat3_q <= sdlat2_q;
    end
  end

  logic          sr_v_q   [NSrch+1];
  logic [QW-1:0] sr_h_q   [NSrch+1];
  logic [QW-1:0] sr_phi_q [NSrch+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_v_q[0] <= 1'b0;
    end else if (en) begin
      sr_v_q[0] <= p3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sr_h_q[0]   <= (hsum > 33'(Q_ONE)) ? Q_ONE : QW'(hsum);
      sr_phi_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < NSrch; i++) begin : g_step
    localparam int unsigned B = NSrch - 1 - i;
    localparam logic [QW-1:0] Bit = QW'(1) << B;
    logic [QW-1:0]   cand, xs, t_h, t_c;
    logic            ok, t_ok, st_v;
    logic [31:0]     st_y;
    logic [2*QW:0]   st_tag;

    assign cand = sr_phi_q[i] | Bit;
    assign ok   = (cand <= HALF_PI_Q30);
    assign xs   = ok ? cand : '0;

    hca_trig #(.IsCos(1'b0), .TagW(2 * QW + 1)) u_step (
      .clk_i, .rst_ni, .en_i(en), .valid_i(sr_v_q[i]), .x_i(xs),
      .tag_i({sr_h_q[i], cand, ok}),
      .valid_o(st_v), .y_o(st_y), .tag_o(st_tag)
    );

    assign {t_h, t_c, t_ok} = st_tag;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sr_v_q[i+1] <= 1'b0;
      end else if (en) begin
        sr_v_q[i+1] <= st_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sr_h_q[i+1]   <= t_h;
        sr_phi_q[i+1] <= (t_ok && (st_y <= 32'(t_h))) ? t_c : (t_c & ~Bit);
      end
    end
  end

  logic [31:0]   ang;
  logic [31:0]   shifted;
  logic [OW-1:0] angc;

  assign ang = {sr_phi_q[NSrch], 1'b0};

  if (Sh > 0) begin : g_rnd
    assign shifted = 32'((33'(ang) + (33'd1 << (Sh - 1))) >> Sh);
  end else begin : g_nornd
    assign shifted = ang;
  end

  assign angc = (shifted > 32'(AngLim)) ? AngLim : OW'(shifted);

  logic          out_v_q;
  logic [OW-1:0] out_ang_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= sr_v_q[NSrch];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_ang_q <= angc;
    end
  end

  assign out_valid_o     = out_v_q;
  assign central_angle_o = out_ang_q;

  a_ang_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> central_angle_o <= AngLim)
    else $error("central angle above pi");

  a_h_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sr_v_q[0] |-> sr_h_q[0] <= Q_ONE)
    else $error("haversine sum above one");

  a_phi_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sr_v_q[NSrch] |-> sr_phi_q[NSrch] <= HALF_PI_Q30)
    else $error("arcsine result above half pi");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(p0_v_q))
    else $error("first stage moved during a stall");
endmodule

FILE: rtl/hca_trig.sv
// Pipelined fixed-point sine-squared or cosine unit with a side-band tag.
module hca_trig
  import hca_pkg::*;
#(
  parameter bit IsCos = 1'b0,
  parameter int unsigned TagW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [QW-1:0]   x_i,
  input  logic [TagW-1:0] tag_i,
  output logic            valid_o,
  output logic [31:0]     y_o,
  output logic [TagW-1:0] tag_o
);
  localparam int unsigned NS = 2 * NTERMS + 3;

  typedef struct packed {
    logic [QW-1:0] x;
    logic [31:0]   x2;
    logic [QW-1:0] t;
    logic [31:0]   p;
  } stage_t;

  stage_t          st_d  [NS];
  stage_t          st_q  [NS];
  logic            v_q   [NS];
  logic [TagW-1:0] tag_q [NS];
  logic [61:0]     xx0;
  logic [61:0]     prod_f;
  logic [63:0]     prod_g;

  assign xx0 = 62'(x_i) * 62'(x_i);

  always_comb begin
    st_d[0].x  = x_i;
    st_d[0].x2 = xx0[61:30];
    st_d[0].t  = Q_ONE;
    st_d[0].p  = '0;
  end

  for (genvar k = 0; k < NTERMS; k++) begin : g_term
    localparam int unsigned D = IsCos ? COS_DIV[k] : SIN_DIV[k];
    localparam int unsigned L = $clog2(D);
    localparam logic [64:0] MW = ((65'd1 << (32 + L)) + 65'(D) - 65'd1) / 65'(D);
    localparam logic [32:0] M = 33'(MW);
    logic [62:0] prod_a;
    logic [64:0] prod_b;
    logic [31:0] quo;

    assign prod_a = 63'(st_q[2*k].x2) * 63'(st_q[2*k].t);
    assign prod_b = 65'(st_q[2*k+1].p) * 65'(M);
    assign quo    = 32'(prod_b >> (32 + L));

    always_comb begin
      st_d[2*k+1]   = st_q[2*k];
      st_d[2*k+1].p = prod_a[61:30];
    end

    always_comb begin
      st_d[2*k+2] = st_q[2*k+1];
      if (quo > 32'(Q_ONE)) begin
        st_d[2*k+2].t = '0;
      end else begin
        st_d[2*k+2].t = QW'(32'(Q_ONE) - quo);
      end
    end
  end

  assign prod_f = 62'(st_q[NS-3].x) * 62'(st_q[NS-3].t);
  assign prod_g = 64'(st_q[NS-2].p) * 64'(st_q[NS-2].p);

  always_comb begin
    st_d[NS-2] = st_q[NS-3];
    if (IsCos) begin
      st_d[NS-2].p = 32'(st_q[NS-3].t);
    end else begin
      st_d[NS-2].p = prod_f[61:30];
    end
  end

  always_comb begin
    st_d[NS-1] = st_q[NS-2];
    if (!IsCos) begin
      st_d[NS-1].p = prod_g[61:30];
    end
  end

  for (genvar j = 0; j < NS; j++) begin : g_reg
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= (j == 0) ? valid_i : v_q[(j == 0) ? 0 : j - 1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[j]  <= st_d[j];
        tag_q[j] <= (j == 0) ? tag_i : tag_q[(j == 0) ? 0 : j - 1];
      end
    end
  end

  assign valid_o = v_q[NS-1];
  assign y_o     = st_q[NS-1].p;
  assign tag_o   = tag_q[NS-1];
endmodule

FILE: tb/sv/haversine_central_angle_tb.sv
// Self-checking testbench for the haversine central angle pipeline.
module haversine_central_angle_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned F = 16;
  localparam int unsigned LATENCY = 517;
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned N_RANDOM = 600;
  localparam logic [63:0] QONE = 64'd1 << 30;

  typedef struct packed {
    logic signed [7:0] lat1;
    logic signed [8:0] lon1;
    logic signed [7:0] lat2;
    logic signed [8:0] lon2;
  } position_pair_t;

  typedef struct {
    position_pair_t pair;
    bit known;
    logic [F+1:0] angle;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [7:0] start_latitude_i = '0;
  logic signed [8:0] start_longitude_i = '0;
  logic signed [7:0] end_latitude_i = '0;
  logic signed [8:0] end_longitude_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [F+1:0] central_angle_o;

  logic [F+1:0] expected_angles[$];
  int unsigned mismatches = 0;
  int unsigned beats_in = 0;
  int unsigned beats_out = 0;
  int unsigned idle_cycles = 0;
  bit stim_done = 1'b0;
  bit calm = 1'b0;
  bit hold_request = 1'b0;

  haversine_central_angle #(.OUT_FRAC_BITS(F)) dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [63:0] taylor_poly(logic [63:0] x2, bit is_sin);
    int unsigned sin_d[6] = '{156, 110, 72, 42, 20, 6};
    int unsigned cos_d[6] = '{132, 90, 56, 30, 12, 2};
    logic [63:0] t;
    logic [63:0] p;
    t = QONE;
    for (int i = 0; i < 6; i++) begin
      p = ((x2 * t) >> 30) / (is_sin ? sin_d[i] : cos_d[i]);
      if (p > QONE) p = QONE;
      t = QONE - p;
    end
    return t;
  endfunction

  function automatic logic [63:0] sine_q30(logic [63:0] x);
    return (x * taylor_poly((x * x) >> 30, 1'b1)) >> 30;
  endfunction

  function automatic logic [63:0] cosine_q30(logic [63:0] x);
    return taylor_poly((x * x) >> 30, 1'b0);
  endfunction

  function automatic logic [63:0] square_q30(logic [63:0] s);
    return (s * s) >> 30;
  endfunction

  function automatic longint clamp_latitude(logic signed [7:0] v);
    longint w;
    w = v;
    if (w > 90) return 90;
    if (w < -90) return -90;
    return w;
  endfunction

  function automatic logic [F+1:0] predict_angle(position_pair_t p);
    longint la1, la2, dl, dn;
    logic [63:0] sdlat, sdlon, c1, c2, h, phi, cand, ang;
    la1 = clamp_latitude(p.lat1);
    la2 = clamp_latitude(p.lat2);
    dl = la1 - la2;
    if (dl < 0) dl = -dl;
    dn = longint'(p.lon1) - longint'(p.lon2);
    if (dn < 0) dn = -dn;
    dn = dn % 360;
    if (dn > 180) dn = 360 - dn;
    sdlat = square_q30(sine_q30(dl * hca_pkg::RAD_HALF_DEG));
    sdlon = square_q30(sine_q30(dn * hca_pkg::RAD_HALF_DEG));
    c1 = cosine_q30((la1 < 0 ? -la1 : la1) * 2 * hca_pkg::RAD_HALF_DEG);
    c2 = cosine_q30((la2 < 0 ? -la2 : la2) * 2 * hca_pkg::RAD_HALF_DEG);
    h = sdlat + ((((c1 * c2) >> 30) * sdlon) >> 30);
    if (h > QONE) h = QONE;
    phi = 0;
    for (int b = 30; b >= 0; b--) begin
      cand = phi | (64'd1 << b);
      if (cand <= hca_pkg::HALF_PI_Q30 && square_q30(sine_q30(cand)) <= h) phi = cand;
    end
    ang = ((2 * phi) + (64'd1 << (29 - F))) >> (30 - F);
    if (ang > (64'(hca_pkg::PI_Q30) >> (30 - F))) ang = 64'(hca_pkg::PI_Q30) >> (30 - F);
    return ang[F+1:0];
  endfunction

  task automatic report_mismatch(string what, logic [F+1:0] got, logic [F+1:0] want);
    $display("MISMATCH %s: central_angle got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  task automatic send_beat(position_pair_t p, bit known, logic [F+1:0] angle);
    int unsigned gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(1, 9);
      repeat (gap) @(negedge clk_i);
    end
    if (known && angle != predict_angle(p)) report_mismatch("table row", predict_angle(p), angle);
    in_valid_i <= 1'b1;
    start_latitude_i <= p.lat1;
    start_longitude_i <= p.lon1;
    end_latitude_i <= p.lat2;
    end_longitude_i <= p.lon2;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_angles.push_back(predict_angle(p));
    beats_in++;
    @(negedge clk_i);
  endtask

  function automatic position_pair_t random_pair();
    position_pair_t p;
    if ($urandom_range(0, 7) == 0) begin
      p = position_pair_t'(34'({$urandom, $urandom}));
    end else begin
      p.lat1 = $urandom_range(0, 180) - 90;
      p.lon1 = $urandom_range(0, 360) - 180;
      p.lat2 = $urandom_range(0, 180) - 90;
      p.lon2 = $urandom_range(0, 360) - 180;
      if ($urandom_range(0, 9) == 0) begin
        p.lat2 = -p.lat1;
        p.lon2 = p.lon1 + 180;
      end
    end
    return p;
  endfunction

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      beats_out++;
      if (expected_angles.size() == 0) begin
        report_mismatch("unexpected beat", central_angle_o, '0);
      end else begin
        logic [F+1:0] want;
        want = expected_angles.pop_front();
        if (central_angle_o !== want) report_mismatch("beat", central_angle_o, want);
      end
    end
  end

  always @(negedge clk_i) begin
    int unsigned hold;
    if (hold_request) begin
      out_stall_i <= 1'b1;
      hold = 1200;
      repeat (hold) @(negedge clk_i);
      out_stall_i <= 1'b0;
      hold_request = 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_stall_i <= 1'b1;
      hold = $urandom_range(1, 9);
      repeat (hold) @(negedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", idle_cycles);
      $display("haversine_central_angle_tb failed");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[$];
    localparam logic [F+1:0] SAME_POINT = 18'd4;
    rows.push_back('{'{8'sd0, 9'sd0, 8'sd0, 9'sd0}, 1, SAME_POINT});
    rows.push_back('{'{8'sd45, 9'sd100, 8'sd45, 9'sd100}, 1, SAME_POINT});
    rows.push_back('{'{8'sd90, 9'sd0, -8'sd90, 9'sd0}, 0, '0});
    rows.push_back('{'{8'sd0, 9'sd0, 8'sd0, 9'sd180}, 0, '0});
    rows.push_back('{'{8'sd0, -9'sd180, 8'sd0, 9'sd0}, 0, '0});
    rows.push_back('{'{8'sd127, 9'sd0, -8'sd128, 9'sd0}, 0, '0});
    rows.push_back('{'{8'sd90, 9'sd10, 8'sd90, -9'sd170}, 0, '0});
    rows.push_back('{'{8'sd0, 9'sd255, 8'sd0, -9'sd256}, 0, '0});
    rows.push_back('{'{8'sd0, 9'sd180, 8'sd0, -9'sd180}, 0, '0});
    rows.push_back('{'{8'sd0, 9'sd0, 8'sd0, 9'sd90}, 0, '0});
    rows.push_back('{'{8'sd30, -9'sd60, -8'sd45, 9'sd120}, 0, '0});
    rows.push_back('{'{-8'sd90, -9'sd180, 8'sd90, 9'sd180}, 0, '0});
    rows.push_back('{'{8'sd1, 9'sd0, 8'sd0, 9'sd1}, 0, '0});
    rows.push_back('{'{-8'sd1, -9'sd1, -8'sd1, -9'sd1}, 0, '0});
    rows.push_back('{'{8'sd60, 9'sd0, 8'sd60, 9'sd179}, 0, '0});
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (rows[i]) send_beat(rows[i].pair, rows[i].known, rows[i].angle);
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 200) hold_request = 1'b1;
      if (n == N_RANDOM - 100) calm = 1'b1;
      send_beat(random_pair(), 1'b0, '0);
    end
    in_valid_i <= 1'b0;
    stim_done = 1'b1;
    while (expected_angles.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 20) @(posedge clk_i);
    $display("Sent %0d position pairs (directed extremes, wraps, antipodes, random and",
             beats_in);
    $display("out-of-range fields) and checked %0d angles.", beats_out);
    if (mismatches == 0) begin
      $display("haversine_central_angle_tb passed");
    end else begin
      $display("haversine_central_angle_tb failed");
    end
    $finish;
  end
endmodule
